/* design/lob_pkg.sv */
// ---------------------------------------------------------------------------
// lob_pkg: shared types and constants for the order book matcher
// Field widths, result kind codes and the resting order entry layout.
// ---------------------------------------------------------------------------
package lob_pkg;

  localparam int LOB_DEPTH_DEF = 16;

  localparam int ID_W   = 32;
  localparam int PX_W   = 32;
  localparam int QTY_W  = 31;
  localparam int KIND_W = 2;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 160;

  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRADE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PX_W-1:0]  price;
    logic [QTY_W-1:0] qty;
  } entry_t;

endpackage

/* design/lob_book.sv */
// ---------------------------------------------------------------------------
// lob_book: storage for one side of the book
// One write port and one registered read port over the resting orders.
// ---------------------------------------------------------------------------
module lob_book
  import lob_pkg::*;
#(
  parameter int  DEPTH = LOB_DEPTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/limit_order_book_matcher_core.sv */
// ---------------------------------------------------------------------------
// limit_order_book_matcher_core: price-time priority order book matcher
// Steps: a reject or an add to an empty side goes straight to the emit state;
//   any other add walks from the tail in ST_INS, shifting one resting order
//   per cycle, then writes the new order and emits the accept beat.
// A match loops head read (ST_M_RD) and compare (ST_M_CMP) on the shared
//   price comparator, one trade per loop, then emits the done beat.
// One item at a time; in_tready is high only while idle, from the cycle the
//   final beat is registered. Output stalls hold the emit, compare and done states.
// Reset: both books empty, no clearing pass; output stage empty.
// ---------------------------------------------------------------------------
module limit_order_book_matcher_core
  import lob_pkg::*;
#(
  parameter int BOOK_DEPTH = LOB_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // order_id[31:0], side[32], price[64:33], quantity[95:65]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // operation[0]
  input  logic [0:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // buy_order_id[31:0], buy_price[63:32], sell_order_id[95:64],
  // sell_price[127:96], traded_quantity[158:128], zero[159]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // kind[1:0]
  output logic [KIND_W-1:0]      out_tuser,
  output logic                   out_tlast
);

  localparam int AW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH + 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_INS      = 3'd1;
  localparam logic [2:0] ST_INS_FIN  = 3'd2;
  localparam logic [2:0] ST_ADD_EMIT = 3'd3;
  localparam logic [2:0] ST_M_RD     = 3'd4;
  localparam logic [2:0] ST_M_CMP    = 3'd5;
  localparam logic [2:0] ST_M_DONE   = 3'd6;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    if (p == AW'(BOOK_DEPTH - 1)) ptr_inc = '0;
    else ptr_inc = p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    if (p == '0) ptr_dec = AW'(BOOK_DEPTH - 1);
    else ptr_dec = p - 1'b1;
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     bid_head_r, bid_head_nxt, ask_head_r, ask_head_nxt;
  logic [CW-1:0]     bid_cnt_r, bid_cnt_nxt, ask_cnt_r, ask_cnt_nxt;
  logic              side_r, side_nxt;
  entry_t            new_r, new_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     walk_r, walk_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic              out_last_r, out_last_nxt;
  logic [ID_W-1:0]   out_bid_r, out_bid_nxt, out_sid_r, out_sid_nxt;
  logic [PX_W-1:0]   out_bpx_r, out_bpx_nxt, out_spx_r, out_spx_nxt;
  logic [QTY_W-1:0]  out_qty_r, out_qty_nxt;

  logic          b_wr_en, b_rd_en, a_wr_en, a_rd_en;
  logic [AW-1:0] b_wr_addr, b_rd_addr, a_wr_addr, a_rd_addr;
  entry_t        b_wr_data, a_wr_data, b_rd_data, a_rd_data;

  // input fields
  logic             in_op, in_side;
  entry_t           in_entry;

  // selected side while idle
  logic [CW-1:0]    sel_cnt;
  logic [AW-1:0]    sel_head, tail;
  logic [AW:0]      tail_sum;
  logic             full;

  // shared comparator and quantity path
  logic [PX_W-1:0]  lt_a, lt_b;
  logic             lt, crossed, out_free;
  entry_t           ins_e, bid_wb, ask_wb;
  logic [QTY_W:0]   q_diff;
  logic [QTY_W-1:0] trade_q, bid_rem, ask_rem;

  assign in_op          = in_tuser[0];
  assign in_side        = in_tdata[32];
  assign in_entry.id    = in_tdata[31:0];
  assign in_entry.price = in_tdata[64:33];
  assign in_entry.qty   = in_tdata[95:65];

  assign sel_cnt  = in_side ? bid_cnt_r : ask_cnt_r;
  assign sel_head = in_side ? bid_head_r : ask_head_r;
  assign full     = (sel_cnt == CW'(BOOK_DEPTH));

  // physical slot just past the last resting order, with wrap
  always_comb begin
    tail_sum = (AW+1)'(sel_head) + (AW+1)'(sel_cnt[AW-1:0]);
    if (tail_sum >= (AW+1)'(BOOK_DEPTH)) tail_sum = tail_sum - (AW+1)'(BOOK_DEPTH);
    tail = tail_sum[AW-1:0];
  end

  assign ins_e = side_r ? b_rd_data : a_rd_data;

  always_comb begin
    if (state_r == ST_M_CMP) begin
      lt_a = b_rd_data.price;
      lt_b = a_rd_data.price;
    end else if (side_r) begin
      lt_a = ins_e.price;
      lt_b = new_r.price;
    end else begin
      lt_a = new_r.price;
      lt_b = ins_e.price;
    end
  end

  assign lt      = (lt_a < lt_b);
  assign crossed = !lt && (bid_cnt_r != '0) && (ask_cnt_r != '0);

  assign q_diff  = {1'b0, b_rd_data.qty} - {1'b0, a_rd_data.qty};
  assign trade_q = q_diff[QTY_W] ? b_rd_data.qty : a_rd_data.qty;
  assign bid_rem = b_rd_data.qty - trade_q;
  assign ask_rem = a_rd_data.qty - trade_q;

  always_comb begin
    bid_wb     = b_rd_data;
    bid_wb.qty = bid_rem;
    ask_wb     = a_rd_data;
    ask_wb.qty = ask_rem;
  end

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    bid_head_nxt  = bid_head_r;
    ask_head_nxt  = ask_head_r;
    bid_cnt_nxt   = bid_cnt_r;
    ask_cnt_nxt   = ask_cnt_r;
    side_nxt      = side_r;
    new_nxt       = new_r;
    kind_nxt      = kind_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    walk_nxt      = walk_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_bid_nxt   = out_bid_r;
    out_bpx_nxt   = out_bpx_r;
    out_sid_nxt   = out_sid_r;
    out_spx_nxt   = out_spx_r;
    out_qty_nxt   = out_qty_r;
    b_wr_en   = 1'b0;
    b_wr_addr = wr_ptr_r;
    b_wr_data = new_r;
    b_rd_en   = 1'b0;
    b_rd_addr = bid_head_r;
    a_wr_en   = 1'b0;
    a_wr_addr = wr_ptr_r;
    a_wr_data = new_r;
    a_rd_en   = 1'b0;
    a_rd_addr = ask_head_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          new_nxt  = in_entry;
          side_nxt = in_side;
          if (in_op) begin
            state_nxt = ST_M_RD;
          end else if (full) begin
            kind_nxt  = KIND_REJECT;
            state_nxt = ST_ADD_EMIT;
          end else if (sel_cnt == '0) begin
            // empty side: the order lands at the head
            kind_nxt  = KIND_ACCEPT;
            state_nxt = ST_ADD_EMIT;
            if (in_side) begin
              b_wr_en     = 1'b1;
              b_wr_addr   = tail;
              b_wr_data   = in_entry;
              bid_cnt_nxt = bid_cnt_r + CW'(1);
            end else begin
              a_wr_en     = 1'b1;
              a_wr_addr   = tail;
              a_wr_data   = in_entry;
              ask_cnt_nxt = ask_cnt_r + CW'(1);
            end
          end else begin
            wr_ptr_nxt = tail;
            rd_ptr_nxt = ptr_dec(tail);
            walk_nxt   = sel_cnt;
            state_nxt  = ST_INS;
            if (in_side) begin
              b_rd_en   = 1'b1;
              b_rd_addr = ptr_dec(tail);
            end else begin
              a_rd_en   = 1'b1;
              a_rd_addr = ptr_dec(tail);
            end
          end
        end
      end

      ST_INS: begin
        // walk from the tail; shift lower-ranked orders up one slot
        if (!lt) begin
          kind_nxt  = KIND_ACCEPT;
          state_nxt = ST_ADD_EMIT;
          if (side_r) begin
            b_wr_en     = 1'b1;
            bid_cnt_nxt = bid_cnt_r + CW'(1);
          end else begin
            a_wr_en     = 1'b1;
            ask_cnt_nxt = ask_cnt_r + CW'(1);
          end
        end else begin
          wr_ptr_nxt = rd_ptr_r;
          if (side_r) begin
            b_wr_en   = 1'b1;
            b_wr_data = ins_e;
          end else begin
            a_wr_en   = 1'b1;
            a_wr_data = ins_e;
          end
          if (walk_r == CW'(1)) begin
            state_nxt = ST_INS_FIN;
          end else begin
            rd_ptr_nxt = ptr_dec(rd_ptr_r);
            walk_nxt   = walk_r - CW'(1);
            if (side_r) begin
              b_rd_en   = 1'b1;
              b_rd_addr = ptr_dec(rd_ptr_r);
            end else begin
              a_rd_en   = 1'b1;
              a_rd_addr = ptr_dec(rd_ptr_r);
            end
          end
        end
      end

      ST_INS_FIN: begin
        kind_nxt  = KIND_ACCEPT;
        state_nxt = ST_ADD_EMIT;
        if (side_r) begin
          b_wr_en     = 1'b1;
          bid_cnt_nxt = bid_cnt_r + CW'(1);
        end else begin
          a_wr_en     = 1'b1;
          ask_cnt_nxt = ask_cnt_r + CW'(1);
        end
      end

      ST_ADD_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_last_nxt  = 1'b1;
          out_bid_nxt   = '0;
          out_bpx_nxt   = '0;
          out_sid_nxt   = '0;
          out_spx_nxt   = '0;
          out_qty_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end

      ST_M_RD: begin
        b_rd_en   = 1'b1;
        a_rd_en   = 1'b1;
        state_nxt = ST_M_CMP;
      end

      ST_M_CMP: begin
        if (!crossed) begin
          state_nxt = ST_M_DONE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_TRADE;
          out_last_nxt  = 1'b0;
          out_bid_nxt   = b_rd_data.id;
          out_bpx_nxt   = b_rd_data.price;
          out_sid_nxt   = a_rd_data.id;
          out_spx_nxt   = a_rd_data.price;
          out_qty_nxt   = trade_q;
          state_nxt     = ST_M_RD;
          // pop a filled order, write back the remainder otherwise
          if (bid_rem == '0) begin
            bid_head_nxt = ptr_inc(bid_head_r);
            bid_cnt_nxt  = bid_cnt_r - CW'(1);
          end else begin
            b_wr_en   = 1'b1;
            b_wr_addr = bid_head_r;
            b_wr_data = bid_wb;
          end
          if (ask_rem == '0) begin
            ask_head_nxt = ptr_inc(ask_head_r);
            ask_cnt_nxt  = ask_cnt_r - CW'(1);
          end else begin
            a_wr_en   = 1'b1;
            a_wr_addr = ask_head_r;
            a_wr_data = ask_wb;
          end
        end
      end

      ST_M_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_DONE;
          out_last_nxt  = 1'b1;
          out_bid_nxt   = '0;
          out_bpx_nxt   = '0;
          out_sid_nxt   = '0;
          out_spx_nxt   = '0;
          out_qty_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bid_head_r  <= '0;
      ask_head_r  <= '0;
      bid_cnt_r   <= '0;
      ask_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bid_head_r  <= bid_head_nxt;
      ask_head_r  <= ask_head_nxt;
      bid_cnt_r   <= bid_cnt_nxt;
      ask_cnt_r   <= ask_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r     <= side_nxt;
    new_r      <= new_nxt;
    kind_r     <= kind_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    walk_r     <= walk_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    out_bid_r  <= out_bid_nxt;
    out_bpx_r  <= out_bpx_nxt;
    out_sid_r  <= out_sid_nxt;
    out_spx_r  <= out_spx_nxt;
    out_qty_r  <= out_qty_nxt;
  end

  lob_book #(.DEPTH(BOOK_DEPTH)) u_bids (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (b_wr_addr),
    .wr_data (b_wr_data),
    .rd_en   (b_rd_en),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  lob_book #(.DEPTH(BOOK_DEPTH)) u_asks (
    .clk     (clk),
    .wr_en   (a_wr_en),
    .wr_addr (a_wr_addr),
    .wr_data (a_wr_data),
    .rd_en   (a_rd_en),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_qty_r, out_spx_r, out_sid_r, out_bpx_r, out_bid_r};

endmodule

/* design/lob_checker.sv */
// ---------------------------------------------------------------------------
// lob_checker: port-level checks for the order book matcher
// Watches the stream ports and flags beats that break the result rules.
// ---------------------------------------------------------------------------
module lob_checker
  import lob_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [KIND_W-1:0]      out_tuser,
  input logic                   out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again in the cycle after a beat");

  // only trade beats leave the run open
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == KIND_TRADE) != out_tlast))
    else $error("tlast does not match result kind");

  // a trade needs crossed prices
  a_cross: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_TRADE) |-> (out_tdata[63:32] >= out_tdata[127:96]))
    else $error("trade with bid below ask");

  // status beats carry an all-zero payload
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_TRADE) |-> (out_tdata == '0))
    else $error("nonzero payload on status beat");

endmodule

bind limit_order_book_matcher_core lob_checker u_lob_checker (.*);
